// ----- sv/cvs_pkg.sv -----
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants of the column variance / standard deviation block.
// ----------------------------------------------------------------------------
package cvs_pkg;

   localparam int MAX_COLS   = 8;
   localparam int MAX_ROWS   = 256;
   localparam int SAMPLE_W   = 24;
   localparam int COL_W      = 3;
   localparam int NCOLS_W    = 4;
   localparam int ROW_AW     = $clog2(MAX_ROWS);
   localparam int CNT_W      = $clog2(MAX_ROWS + 1);
   localparam int SUM_W      = 32;
   localparam int ACC_W      = 58;
   localparam int PROD_W     = 50;
   localparam int SPREAD_W   = 50;
   localparam int STATUS_W   = 2;
   localparam int ROOT_W     = 29;
   localparam int ROW_W      = MAX_COLS * SAMPLE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NCOLS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT      = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

   typedef struct packed {
      logic              load;
      logic              col_init;
      logic              div_start;
      logic              div_sel;     // 0 mean, 1 variance
      logic              mean_take;
      logic              rd_en;
      logic [ROW_AW-1:0] rd_row;
      logic              var_take;
      logic              root_start;
      logic              root_take;
      logic              emit;
      logic              run_clear;
      logic [COL_W-1:0]  col;
   } cvs_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] n;
      logic             n_zero;
      logic             d_zero;
      logic             last_col;
      logic             div_done;
      logic             root_done;
      logic             give_root;
      logic             out_busy;
   } cvs_sts_type;

endpackage

// ----- sv/column_variance_stddev_top.sv -----
// ----------------------------------------------------------------------------
// column_variance_stddev_top
// Per-column mean and sample or population variance, or standard deviation, of a loaded matrix.
// ----------------------------------------------------------------------------
// Elements load at one item per clock while the block is loading. Up to 256
// rows of 8 columns are kept in a row-wide store. The item flagged last
// starts the compute pass, during which no input is taken. Each column in
// use then goes through the mean (a start step, then the bit-serial
// divider), the deviation pass (one store row read per cycle), the final
// division and, when enabled, the square root, and then the hand-off of the
// result to the output register, which waits while that register is still
// held by the output side. With no rows a column goes straight to the
// hand-off. Loading of the next data set starts once the result for the last
// column is in that register.
module column_variance_stddev_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // sample, col
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [79:0]                       rsp_tdata,   // out_col, mean, spread
   output logic [cvs_pkg::STATUS_W-1:0]      rsp_tuser,   // status
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [cvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cvs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cvs_pkg::cvs_cmd_type                cmd;
   cvs_pkg::cvs_sts_type                sts;
   logic [cvs_pkg::COL_W-1:0]           out_col;
   logic [cvs_pkg::SAMPLE_W-1:0]        out_mean;
   logic [cvs_pkg::SPREAD_W-1:0]        out_spread;

   cvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cvs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_sample  (req_tdata[cvs_pkg::SAMPLE_W-1:0]),
      .in_col     (req_tdata[cvs_pkg::SAMPLE_W +: cvs_pkg::COL_W]),
      .in_last    (req_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_col    (out_col),
      .out_mean   (out_mean),
      .out_spread (out_spread),
      .out_status (rsp_tuser),
      .out_end    (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_spread, out_mean, out_col};

endmodule

// ----- sv/cvs_ram.sv -----
// ----------------------------------------------------------------------------
// cvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- sv/cvs_div.sv -----
// ----------------------------------------------------------------------------
// cvs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cvs_pkg::ACC_W-1:0]  dividend,
   input  logic [cvs_pkg::CNT_W-1:0]  divisor,
   output logic [cvs_pkg::ACC_W-1:0]  quotient,
   output logic                       done
);

   localparam int CW = $clog2(cvs_pkg::ACC_W);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CW-1:0]                cnt_ff;
   logic [cvs_pkg::CNT_W-1:0]    rem_ff;
   logic [cvs_pkg::ACC_W-1:0]    quo_ff;
   logic [cvs_pkg::CNT_W:0]      trial;
   logic                         fits;

   assign trial = {rem_ff, quo_ff[cvs_pkg::ACC_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(cvs_pkg::ACC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? cvs_pkg::CNT_W'(trial - {1'b0, divisor})
                        : trial[cvs_pkg::CNT_W-1:0];
         quo_ff <= {quo_ff[cvs_pkg::ACC_W-2:0], fits};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- sv/cvs_isqrt.sv -----
// ----------------------------------------------------------------------------
// cvs_isqrt
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cvs_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cvs_pkg::ACC_W-1:0]  value,
   output logic [cvs_pkg::ROOT_W-1:0] root,
   output logic                       done
);

   localparam int CW = $clog2(cvs_pkg::ROOT_W);

   logic                      busy_ff;
   logic                      done_ff;
   logic [CW-1:0]             cnt_ff;
   logic [cvs_pkg::ACC_W-1:0] v_ff;
   logic [cvs_pkg::ACC_W-1:0] res_ff;
   logic [cvs_pkg::ACC_W-1:0] bit_ff;
   logic [cvs_pkg::ACC_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(cvs_pkg::ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= value;
         res_ff <= '0;
         bit_ff <= cvs_pkg::ACC_W'(1) << (2 * (cvs_pkg::ROOT_W - 1));
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = res_ff[cvs_pkg::ROOT_W-1:0];
   assign done = done_ff;

endmodule

// ----- sv/cvs_datapath.sv -----
// ----------------------------------------------------------------------------
// cvs_datapath
// Row buffer, sample store, column sums, deviation accumulator, divider,
// square root unit and result register.
// ----------------------------------------------------------------------------
module cvs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  cvs_pkg::cvs_cmd_type            cmd,
   output cvs_pkg::cvs_sts_type            sts,
   input  logic signed [cvs_pkg::SAMPLE_W-1:0] in_sample,
   input  logic [cvs_pkg::COL_W-1:0]       in_col,
   input  logic                            in_last,
   input  logic                            csr_wr_en,
   input  logic [cvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cvs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [cvs_pkg::COL_W-1:0]       out_col,
   output logic [cvs_pkg::SAMPLE_W-1:0]    out_mean,
   output logic [cvs_pkg::SPREAD_W-1:0]    out_spread,
   output logic [cvs_pkg::STATUS_W-1:0]    out_status,
   output logic                            out_end
);

   localparam int SW = cvs_pkg::SAMPLE_W;

   logic                             norm_ff;
   logic [cvs_pkg::NCOLS_W-1:0]      ncols_ff;
   logic                             root_ff;
   logic [cvs_pkg::NCOLS_W-1:0]      eff_cols;

   logic signed [cvs_pkg::SUM_W-1:0] sums_ff [cvs_pkg::MAX_COLS];
   logic signed [SW-1:0]             buf_ff [cvs_pkg::MAX_COLS];
   logic [cvs_pkg::MAX_COLS-1:0]     written_ff;
   logic [cvs_pkg::MAX_COLS-1:0]     written_upd;
   logic [cvs_pkg::CNT_W-1:0]        rows_ff;
   logic                             overflow_ff;

   logic                             in_range;
   logic                             full;
   logic                             store;
   logic                             row_end;
   logic                             close;
   logic [cvs_pkg::ROW_W-1:0]        row_data;
   logic [cvs_pkg::ROW_W-1:0]        ram_rd_data;

   logic signed [cvs_pkg::SUM_W-1:0] sum_sel;
   logic [cvs_pkg::SUM_W-1:0]        sum_mag;
   logic [cvs_pkg::CNT_W-1:0]        divisor_d;
   logic [cvs_pkg::ACC_W-1:0]        div_dividend;
   logic [cvs_pkg::CNT_W-1:0]        div_divisor;
   logic [cvs_pkg::ACC_W-1:0]        div_q;
   logic                             div_done;
   logic [cvs_pkg::ROOT_W-1:0]       root;
   logic                             root_done;

   logic signed [SW-1:0]             mean_ff;
   logic signed [SW-1:0]             rd_sample;
   logic signed [SW:0]               dv;
   logic [SW:0]                      ad;
   logic                             rd_vld_ff;
   logic                             prod_vld_ff;
   logic [cvs_pkg::PROD_W-1:0]       prod_ff;
   logic [cvs_pkg::ACC_W-1:0]        acc_ff;
   logic [cvs_pkg::SPREAD_W-1:0]     spread_ff;
   logic                             d_zero;

   logic                             out_valid_ff;
   logic [cvs_pkg::COL_W-1:0]        out_col_ff;
   logic [SW-1:0]                    out_mean_ff;
   logic [cvs_pkg::SPREAD_W-1:0]     out_spread_ff;
   logic [cvs_pkg::STATUS_W-1:0]     out_status_ff;
   logic                             out_end_ff;

   function automatic logic [cvs_pkg::COL_W-1:0] COL_W_k(input int k);
      return cvs_pkg::COL_W'(k);
   endfunction

   always_comb begin
      if (ncols_ff == '0) begin
         eff_cols = cvs_pkg::NCOLS_W'(1);
      end else if (ncols_ff > cvs_pkg::NCOLS_W'(cvs_pkg::MAX_COLS)) begin
         eff_cols = cvs_pkg::NCOLS_W'(cvs_pkg::MAX_COLS);
      end else begin
         eff_cols = ncols_ff;
      end
   end

   // load side
   assign in_range    = {1'b0, in_col} < eff_cols;
   assign full        = rows_ff >= cvs_pkg::CNT_W'(cvs_pkg::MAX_ROWS);
   assign store       = cmd.load && in_range && !full;
   assign row_end     = store && ({1'b0, in_col} == eff_cols - 1'b1);
   assign written_upd = written_ff | (store ? (cvs_pkg::MAX_COLS'(1) << in_col) : '0);
   assign close       = row_end || (cmd.load && in_last && (|written_upd) && !full);

   always_comb begin
      for (int k = 0; k < cvs_pkg::MAX_COLS; k++) begin
         if (store && (in_col == COL_W_k(k))) begin
            row_data[k*SW +: SW] = in_sample;
         end else if (written_ff[k]) begin
            row_data[k*SW +: SW] = buf_ff[k];
         end else begin
            row_data[k*SW +: SW] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         buf_ff[in_col] <= in_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff     <= 1'b0;
         ncols_ff    <= cvs_pkg::NCOLS_W'(8);
         root_ff     <= 1'b1;
         written_ff  <= '0;
         rows_ff     <= '0;
         overflow_ff <= 1'b0;
         for (int k = 0; k < cvs_pkg::MAX_COLS; k++) begin
            sums_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               cvs_pkg::CSR_NORMALIZE: norm_ff  <= csr_wdata[0];
               cvs_pkg::CSR_NCOLS:     ncols_ff <= csr_wdata;
               cvs_pkg::CSR_ROOT:      root_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.load && in_range && full) begin
            overflow_ff <= 1'b1;
         end
         if (store) begin
            sums_ff[in_col] <= sums_ff[in_col]
               + cvs_pkg::SUM_W'(in_sample)
               - (written_ff[in_col] ? cvs_pkg::SUM_W'(buf_ff[in_col])
                                     : cvs_pkg::SUM_W'(0));
         end
         if (close) begin
            written_ff <= '0;
            rows_ff    <= rows_ff + 1'b1;
         end else begin
            written_ff <= written_upd;
         end
         if (cmd.run_clear) begin
            written_ff  <= '0;
            rows_ff     <= '0;
            overflow_ff <= 1'b0;
            for (int k = 0; k < cvs_pkg::MAX_COLS; k++) begin
               sums_ff[k] <= '0;
            end
         end
      end
   end

   cvs_ram #(
      .WIDTH (cvs_pkg::ROW_W),
      .DEPTH (cvs_pkg::MAX_ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (close),
      .wr_addr (rows_ff[cvs_pkg::ROW_AW-1:0]),
      .wr_data (row_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_row),
      .rd_data (ram_rd_data)
   );

   // compute side
   assign sum_sel   = sums_ff[cmd.col];
   assign sum_mag   = sum_sel[cvs_pkg::SUM_W-1] ? cvs_pkg::SUM_W'(-sum_sel)
                                                : cvs_pkg::SUM_W'(sum_sel);
   assign divisor_d = norm_ff ? rows_ff
                              : ((rows_ff == '0) ? rows_ff : rows_ff - 1'b1);
   assign d_zero    = (divisor_d == '0);

   assign div_dividend = cmd.div_sel ? acc_ff : cvs_pkg::ACC_W'(sum_mag);
   assign div_divisor  = cmd.div_sel ? divisor_d : rows_ff;

   cvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   cvs_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.root_start),
      .value  (div_q),
      .root   (root),
      .done   (root_done)
   );

   assign rd_sample = ram_rd_data[cmd.col*SW +: SW];
   assign dv        = (SW+1)'(rd_sample) - (SW+1)'(mean_ff);
   assign ad        = dv[SW] ? (SW+1)'(-dv) : (SW+1)'(dv);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd_en;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= ad * ad;
      if (cmd.col_init) begin
         acc_ff    <= '0;
         mean_ff   <= '0;
         spread_ff <= '0;
      end else begin
         if (prod_vld_ff) begin
            acc_ff <= acc_ff + cvs_pkg::ACC_W'(prod_ff);
         end
         if (cmd.mean_take) begin
            mean_ff <= sum_sel[cvs_pkg::SUM_W-1] ? SW'(-div_q[SW-1:0])
                                                 : SW'(div_q[SW-1:0]);
         end
         if (cmd.var_take) begin
            spread_ff <= div_q[cvs_pkg::SPREAD_W-1:0];
         end
         if (cmd.root_take) begin
            spread_ff <= cvs_pkg::SPREAD_W'(root);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_col_ff    <= cmd.col;
         out_mean_ff   <= mean_ff;
         out_spread_ff <= spread_ff;
         out_end_ff    <= sts.last_col;
         if (d_zero) begin
            out_status_ff <= cvs_pkg::STATUS_DIV_ZERO;
         end else if (overflow_ff) begin
            out_status_ff <= cvs_pkg::STATUS_DROPPED;
         end else begin
            out_status_ff <= cvs_pkg::STATUS_OK;
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_col    = out_col_ff;
   assign out_mean   = out_mean_ff;
   assign out_spread = out_spread_ff;
   assign out_status = out_status_ff;
   assign out_end    = out_end_ff;

   assign sts.n         = rows_ff;
   assign sts.n_zero    = (rows_ff == '0);
   assign sts.d_zero    = d_zero;
   assign sts.last_col  = ({1'b0, cmd.col} == eff_cols - 1'b1);
   assign sts.div_done  = div_done;
   assign sts.root_done = root_done;
   assign sts.give_root = root_ff;
   assign sts.out_busy  = out_valid_ff && !out_ready;

endmodule

// ----- sv/cvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cvs_ctrl
// Sequencer: load phase, then per column mean, deviation pass, divide, root
// and result hand-off.
// ----------------------------------------------------------------------------
module cvs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  cvs_pkg::cvs_sts_type sts,
   output cvs_pkg::cvs_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_COL_START,
      ST_MEAN_WAIT,
      ST_DEV_RD,
      ST_DEV_DRAIN,
      ST_VAR_WAIT,
      ST_ROOT_WAIT,
      ST_EMIT
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [cvs_pkg::COL_W-1:0]  col_ff;
   logic [cvs_pkg::COL_W-1:0]  col_in;
   logic [cvs_pkg::CNT_W-1:0]  row_ff;
   logic [cvs_pkg::CNT_W-1:0]  row_in;
   logic [1:0]                 drain_ff;
   logic [1:0]                 drain_in;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      cmd      = '0;
      cmd.col  = col_ff;
      cmd.rd_row = row_ff[cvs_pkg::ROW_AW-1:0];
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               col_in   = '0;
               state_in = ST_COL_START;
            end
         end
         ST_COL_START: begin
            cmd.col_init = 1'b1;
            row_in       = '0;
            if (sts.n_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_MEAN_WAIT;
            end
         end
         ST_MEAN_WAIT: begin
            if (sts.div_done) begin
               cmd.mean_take = 1'b1;
               state_in      = ST_DEV_RD;
            end
         end
         ST_DEV_RD: begin
            cmd.rd_en = 1'b1;
            if (row_ff == sts.n - 1'b1) begin
               drain_in = '0;
               state_in = ST_DEV_DRAIN;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_DEV_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd2) begin
               if (sts.d_zero) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = 1'b1;
                  state_in      = ST_VAR_WAIT;
               end
            end
         end
         ST_VAR_WAIT: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               if (sts.give_root) begin
                  cmd.root_start = 1'b1;
                  state_in       = ST_ROOT_WAIT;
               end else begin
                  cmd.var_take = 1'b1;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_ROOT_WAIT: begin
            if (sts.root_done) begin
               cmd.root_take = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               if (sts.last_col) begin
                  cmd.run_clear = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_COL_START;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

endmodule
